### hdl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// shared sizes, codes and types of the stateful packet filter
// ----------------------------------------------------------------------------
package spf_pkg;

    // table sizes
    localparam int RULE_SLOTS    = 16;
    localparam int SESSION_SLOTS = 64;

    // fixed field widths
    localparam int RULE_INDEX_W = 4;
    localparam int RULE_COUNT_W = 5;
    localparam int REASON_W     = 3;

    // address and counter widths derived from the table sizes
    localparam int RA_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int RC_W = $clog2(RULE_SLOTS + 1);
    localparam int SA_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
    localparam int SC_W = $clog2(SESSION_SLOTS + 1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QA_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // item class
    typedef logic [1:0] op_t;
    localparam op_t OP_PACKET    = 2'd0;
    localparam op_t OP_RULE_WR   = 2'd1;
    localparam op_t OP_RULE_SKIP = 2'd2;

    // verdict reasons
    typedef logic [REASON_W-1:0] reason_t;
    localparam reason_t REASON_SESSION_HIT   = 3'd0;
    localparam reason_t REASON_RULE_PERMIT   = 3'd1;
    localparam reason_t REASON_RULE_DENY     = 3'd2;
    localparam reason_t REASON_NO_MATCH      = 3'd3;
    localparam reason_t REASON_RULE_WRITTEN  = 3'd4;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
    } flow_t;

    typedef struct packed {
        flow_t flow;
        logic  allow;
    } rule_t;

    typedef struct packed {
        op_t             op;
        flow_t           flow;
        logic [RA_W-1:0] rule_addr;
        logic            rule_allow;
    } item_t;

    typedef struct packed {
        logic    accept;
        reason_t reason;
        logic    session_full;
    } verdict_t;

    // handshake of the queue read side
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

### hdl/spf_intf.sv
// ----------------------------------------------------------------------------
// spf channel interfaces
// packet/rule input channel and verdict output channel
// ----------------------------------------------------------------------------
interface spf_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  rule_index;
    logic        rule_allow;

    modport source (
        output valid, command, src_addr, dst_addr, sport, dport,
               rule_index, rule_allow,
        input  ready
    );
    modport sink (
        input  valid, command, src_addr, dst_addr, sport, dport,
               rule_index, rule_allow,
        output ready
    );
endinterface

interface spf_out_if;
    logic       valid;
    logic       ready;
    logic       accept;
    logic [2:0] verdict_reason;
    logic       session_full;

    modport source (
        output valid, accept, verdict_reason, session_full,
        input  ready
    );
    modport sink (
        input  valid, accept, verdict_reason, session_full,
        output ready
    );
endinterface

### hdl/stateful_packet_filter.sv
// ----------------------------------------------------------------------------
// stateful_packet_filter
// session table lookup and ordered rule match with session learning
// ----------------------------------------------------------------------------
//
//  channel      dir   handshake            beat contents
//  pkt_in       in    valid/ready          command, addresses, ports, rule slot
//  result_out   out   valid/ready          accept, verdict_reason, session_full
//  cfg_wr_*     in    write enable only    rule_count (5 bits)
//
//  a packet scans the recorded sessions in the lookup engine and then the rule
//  slots from zero up to limit, where limit is min(rule_count, rule slots),
//  and stops at the first session or rule that matches; both scans read one
//  entry per cycle from the session and rule memory read ports
//  asynchronous active-low reset clears session count, rule_count and all
//  handshake state; table contents are not cleared
//  input and output stall independently: a 2-entry queue sits between the
//  input stage and the engine, and the verdict sits in an output register
//
module stateful_packet_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    spf_in_if.sink                           pkt_in,
    spf_out_if.source                        result_out,
    input  logic                             cfg_wr_en,
    input  logic [spf_pkg::RULE_COUNT_W-1:0] cfg_wr_data
);
    import spf_pkg::*;

    // number of rules searched, from slot zero, capped at the rule slots
    logic [RULE_COUNT_W-1:0] rule_count_reg;

    // input stage to queue
    logic        push_valid;
    logic        push_ready;
    item_t       push_item;

    // queue to engine
    queue_head_t head;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            rule_count_reg <= cfg_wr_data;
        end
    end

    // front: registers each beat and tags it as packet, rule write or rule skip
    spf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_in     (pkt_in),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    // decoupling queue, keeps the input taking beats while the engine scans
    spf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    // back: table updates, scans and the verdict register
    spf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .rule_count (rule_count_reg),
        .result_out (result_out)
    );

endmodule

### hdl/spf_front.sv
// ----------------------------------------------------------------------------
// spf_front
// input stage: takes beats, classifies them and pushes them to the queue
// ----------------------------------------------------------------------------
module spf_front (
    input  logic            clk,
    input  logic            rst_n,
    spf_in_if.sink          pkt_in,
    output logic            push_valid,
    output spf_pkg::item_t  push_item,
    input  logic            push_ready
);
    import spf_pkg::*;

    localparam int IDX_EXT_W = (RA_W > RULE_INDEX_W) ? RA_W : RULE_INDEX_W;

    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    item_t                stage_item_reg;
    item_t                item_next;
    logic                 beat_taken;
    logic [IDX_EXT_W-1:0] idx_ext;

    assign pkt_in.ready = !stage_valid_reg || push_ready;
    assign beat_taken   = pkt_in.valid && pkt_in.ready;
    assign idx_ext      = IDX_EXT_W'(pkt_in.rule_index);

    // classify the beat
    always_comb
    begin
        item_next.flow.src_addr = pkt_in.src_addr;
        item_next.flow.dst_addr = pkt_in.dst_addr;
        item_next.flow.sport    = pkt_in.sport;
        item_next.flow.dport    = pkt_in.dport;
        item_next.rule_addr     = idx_ext[RA_W-1:0];
        item_next.rule_allow    = pkt_in.rule_allow;
        if (!pkt_in.command)
        begin
            item_next.op = OP_PACKET;
        end
        else if (int'(pkt_in.rule_index) < RULE_SLOTS)
        begin
            item_next.op = OP_RULE_WR;
        end
        else
        begin
            item_next.op = OP_RULE_SKIP;
        end
    end

    assign stage_valid_next = beat_taken || (stage_valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_taken)
        begin
            stage_item_reg <= item_next;
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

endmodule

### hdl/spf_queue.sv
// ----------------------------------------------------------------------------
// spf_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module spf_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  spf_pkg::item_t         push_item,
    output logic                   push_ready,
    output spf_pkg::queue_head_t   head,
    input  logic                   pop
);
    import spf_pkg::*;

    item_t            entries_reg [QUEUE_DEPTH];
    logic [QA_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != QC_W'(QUEUE_DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/spf_back.sv
// ----------------------------------------------------------------------------
// spf_back
// lookup engine: rule write, session scan, rule scan, session insert, verdict register
// ----------------------------------------------------------------------------
module spf_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spf_pkg::queue_head_t             head,
    output logic                             pop,
    input  logic [spf_pkg::RULE_COUNT_W-1:0] rule_count,
    spf_out_if.source                        result_out
);
    import spf_pkg::*;

    localparam int IX_W  = (SC_W > RC_W) ? SC_W : RC_W;
    localparam int LIM_W = (RC_W > RULE_COUNT_W) ? RC_W : RULE_COUNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SESS = 2'd1;
    localparam logic [1:0] ST_RULE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // tables
    flow_t sess_mem [SESSION_SLOTS];
    rule_t rule_mem [RULE_SLOTS];
    flow_t sess_rd_reg;
    rule_t rule_rd_reg;

    logic [1:0]       state_reg, state_next;
    logic [IX_W-1:0]  idx_reg, idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [SC_W-1:0]  fill_reg, fill_next;
    flow_t            flow_reg, flow_next;
    verdict_t         res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    verdict_t         out_reg;
    logic             out_load;

    logic             sess_we;
    logic             rule_we;
    logic [LIM_W-1:0] count_ext;
    logic [RC_W-1:0]  rule_limit;
    logic             sess_hit;
    logic             rule_hit;
    logic             out_free;

    assign count_ext  = LIM_W'(rule_count);
    assign rule_limit = (count_ext > LIM_W'(RULE_SLOTS)) ? RC_W'(RULE_SLOTS)
                                                         : RC_W'(count_ext);

    assign sess_hit = cmp_valid_reg && (sess_rd_reg == flow_reg);
    assign rule_hit = cmp_valid_reg && (rule_rd_reg.flow == flow_reg);
    assign out_free = !out_valid_reg || result_out.ready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        fill_next      = fill_reg;
        flow_next      = flow_reg;
        res_next       = res_reg;
        pop            = 1'b0;
        sess_we        = 1'b0;
        rule_we        = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop       = 1'b1;
                    flow_next = head.item.flow;
                    idx_next  = '0;
                    case (head.item.op)
                        OP_PACKET:
                        begin
                            state_next = ST_SESS;
                        end
                        OP_RULE_WR:
                        begin
                            rule_we    = 1'b1;
                            res_next   = '{1'b0, REASON_RULE_WRITTEN, 1'b0};
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            res_next   = '{1'b0, REASON_RULE_WRITTEN, 1'b0};
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SESS:
            begin
                if (sess_hit)
                begin
                    res_next   = '{1'b1, REASON_SESSION_HIT, 1'b0};
                    state_next = ST_EMIT;
                end
                else if (idx_reg < IX_W'(fill_reg))
                begin
                    idx_next       = idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_RULE;
                end
            end
            ST_RULE:
            begin
                if (rule_hit)
                begin
                    state_next = ST_EMIT;
                    if (!rule_rd_reg.allow)
                    begin
                        res_next = '{1'b0, REASON_RULE_DENY, 1'b0};
                    end
                    else if (fill_reg < SC_W'(SESSION_SLOTS))
                    begin
                        sess_we   = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        res_next  = '{1'b1, REASON_RULE_PERMIT, 1'b0};
                    end
                    else
                    begin
                        res_next = '{1'b1, REASON_RULE_PERMIT, 1'b1};
                    end
                end
                else if (idx_reg < IX_W'(rule_limit))
                begin
                    idx_next       = idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    res_next   = '{1'b0, REASON_NO_MATCH, 1'b0};
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flow_reg <= flow_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // session table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (sess_we)
        begin
            sess_mem[fill_reg[SA_W-1:0]] <= flow_reg;
        end
        sess_rd_reg <= sess_mem[idx_reg[SA_W-1:0]];
    end

    // rule table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (rule_we)
        begin
            rule_mem[head.item.rule_addr] <= '{head.item.flow, head.item.rule_allow};
        end
        rule_rd_reg <= rule_mem[idx_reg[RA_W-1:0]];
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.accept         = out_reg.accept;
    assign result_out.verdict_reason = out_reg.reason;
    assign result_out.session_full   = out_reg.session_full;

endmodule

### hdl/spf_checker.sv
// ----------------------------------------------------------------------------
// spf_checker
// port-level checks of the stateful packet filter, bound to the top level
// ----------------------------------------------------------------------------
module spf_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       out_accept,
    input  logic [2:0] out_reason,
    input  logic       out_full
);
    import spf_pkg::*;

    // beats taken but not yet answered
    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!in_beat && out_beat)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_accept)
            && $stable(out_reason) && $stable(out_full))
        else $error("verdict changed while stalled");

    // accept follows the reason
    a_accept_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_accept == (out_reason == REASON_SESSION_HIT
            || out_reason == REASON_RULE_PERMIT))
        else $error("accept does not match reason");

    // a full session table only shows on a permit
    a_full_permit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_full |-> out_reason == REASON_RULE_PERMIT)
        else $error("session_full without a rule permit");

    // no verdict without an input beat behind it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> pending_reg != 4'd0)
        else $error("verdict without a pending input beat");

endmodule

bind stateful_packet_filter spf_checker u_spf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pkt_in.valid),
    .in_ready   (pkt_in.ready),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_accept (result_out.accept),
    .out_reason (result_out.verdict_reason),
    .out_full   (result_out.session_full)
);
